[hdl/ascii_hex_frame_builder_top_defines.svh]
// ----------------------------------------------------------------------------
// ASCII hex frame builder assertion macros
// Shared concurrent assertion forms, clocked on clk_i and idle during reset.
// ----------------------------------------------------------------------------
`ifndef ASCII_HEX_FRAME_BUILDER_TOP_DEFINES_SVH
`define ASCII_HEX_FRAME_BUILDER_TOP_DEFINES_SVH

// Checks the consequent in the same cycle as the antecedent.
`define AHFB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks the consequent in the cycle after the antecedent.
`define AHFB_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/ahfb_pkg.sv]
// ----------------------------------------------------------------------------
// ASCII hex frame builder package
// Payload types, command queue entry, register map and character helpers.
// ----------------------------------------------------------------------------
package ahfb_pkg;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_INFO  = 1'b1
  } func_e;

  typedef struct packed {
    logic       func;
    logic [7:0] device_address;
    logic [7:0] command_code;
    logic [7:0] info_length;
    logic [7:0] info_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       frame_end;
  } out_item_t;

  typedef enum logic {
    CMD_START,
    CMD_INFO
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] addr;
    logic [7:0] code;
    logic [7:0] data;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic [7:0] start_char;
    logic [7:0] end_char;
    logic [7:0] protocol_version;
    logic [7:0] device_type;
  } cfg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_HDR,
    BK_TRL
  } back_mode_e;

  typedef struct packed {
    logic emit;
    logic cmd_pop;
  } back_status_t;

  typedef enum logic [1:0] {
    REG_START_CHAR,
    REG_END_CHAR,
    REG_PROTOCOL_VERSION,
    REG_DEVICE_TYPE
  } reg_idx_e;

  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned StepW    = 4;

  localparam logic [StepW-1:0] HdrFirstStep = 4'd1;
  localparam logic [StepW-1:0] HdrLastStep  = 4'd12;
  localparam logic [StepW-1:0] TrlLastStep  = 4'd4;

  localparam logic [7:0] StartCharRst = 8'd126;
  localparam logic [7:0] EndCharRst   = 8'd13;
  localparam logic [7:0] VersionRst   = 8'd32;
  localparam logic [7:0] DevTypeRst   = 8'd64;

  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharA    = 8'h41;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] res;
    if (nib < 4'd10) begin
      res = CharZero + {4'h0, nib};
    end else begin
      res = CharA + {4'h0, 4'(nib - 4'd10)};
    end
    return res;
  endfunction

endpackage

[hdl/ascii_hex_frame_builder_top.sv]
// A queued item passes the command queue and the output register on its way
// to the result ports. One character leaves per cycle while the slot is free;
// a start item gives the start char and header; a frame's last item the trailer.
// Items are taken every cycle while the command queue has room.
// Reset clears the queue, the sequencer, the output valid flag and the
// configuration registers to their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// ASCII hex frame builder top level
// Configuration registers, front end, command queue and character sequencer.
// ----------------------------------------------------------------------------
`include "ascii_hex_frame_builder_top_defines.svh"

module ascii_hex_frame_builder_top
  import ahfb_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  input  in_item_t            in_item_i,
  output logic                full,
  output logic                empty,
  input  logic                pop,
  output out_item_t           out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  cfg_t         cfg_q;
  logic         cfg_wr;
  reg_idx_e     reg_idx;
  logic         item_ready;
  logic         cmd_push;
  cmd_t         cmd_in;
  cmd_t         cmd_out;
  logic         q_full;
  logic         q_empty;
  logic         out_valid;
  back_status_t back_status;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[CfgAddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_char       <= StartCharRst;
      cfg_q.end_char         <= EndCharRst;
      cfg_q.protocol_version <= VersionRst;
      cfg_q.device_type      <= DevTypeRst;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_START_CHAR:       cfg_q.start_char       <= pwdata[7:0];
        REG_END_CHAR:         cfg_q.end_char         <= pwdata[7:0];
        REG_PROTOCOL_VERSION: cfg_q.protocol_version <= pwdata[7:0];
        REG_DEVICE_TYPE:      cfg_q.device_type      <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_START_CHAR:       prdata = {24'h0, cfg_q.start_char};
      REG_END_CHAR:         prdata = {24'h0, cfg_q.end_char};
      REG_PROTOCOL_VERSION: prdata = {24'h0, cfg_q.protocol_version};
      REG_DEVICE_TYPE:      prdata = {24'h0, cfg_q.device_type};
      default:              prdata = 32'h0;
    endcase
  end

  ahfb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (push),
    .item_i       (in_item_i),
    .q_full_i     (q_full),
    .item_ready_o (item_ready),
    .cmd_push_o   (cmd_push),
    .cmd_o        (cmd_in)
  );

  assign full = !item_ready;

  ahfb_cmd_fifo #(
    .Depth (QueueDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .pop_i   (back_status.cmd_pop),
    .data_o  (cmd_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  ahfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd_out),
    .cmd_empty_i (q_empty),
    .pop_i       (pop),
    .out_item_o  (out_item_o),
    .out_valid_o (out_valid),
    .status_o    (back_status)
  );

  assign empty = !out_valid;

  `AHFB_ASSERT_NXT(a_emit_fills_output, back_status.emit, !empty, "Emitted character was lost")
  `AHFB_ASSERT_IMP(a_emit_slot_free, back_status.emit, empty || pop, "Output overwritten")
  `AHFB_ASSERT_IMP(a_full_after_push, $rose(q_full), $past(cmd_push), "Queue filled without push")

endmodule

[hdl/ahfb_front.sv]
// ----------------------------------------------------------------------------
// ASCII hex frame builder front end
// Accepts items, tracks the expected info bytes and queues frame commands.
// ----------------------------------------------------------------------------
module ahfb_front
  import ahfb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     item_valid_i,
  input  in_item_t item_i,
  input  logic     q_full_i,
  output logic     item_ready_o,
  output logic     cmd_push_o,
  output cmd_t     cmd_o
);

  logic [7:0] bytes_left_q, bytes_left_d;
  logic       accept;

  assign item_ready_o = !q_full_i;
  assign accept       = item_valid_i && !q_full_i;

  always_comb begin
    bytes_left_d = bytes_left_q;
    cmd_push_o   = 1'b0;
    cmd_o.kind   = CMD_START;
    cmd_o.addr   = item_i.device_address;
    cmd_o.code   = item_i.command_code;
    cmd_o.data   = item_i.info_length;
    cmd_o.last   = 1'b0;
    if (accept) begin
      if (item_i.func == FUNC_START) begin
        cmd_push_o   = 1'b1;
        bytes_left_d = item_i.info_length;
      end else if (bytes_left_q != 8'd0) begin
        cmd_push_o   = 1'b1;
        cmd_o.kind   = CMD_INFO;
        cmd_o.data   = item_i.info_byte;
        cmd_o.last   = (bytes_left_q == 8'd1);
        bytes_left_d = bytes_left_q - 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q <= 8'd0;
    end else begin
      bytes_left_q <= bytes_left_d;
    end
  end

endmodule

[hdl/ahfb_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// ASCII hex frame builder command queue
// Short queue that decouples the front end from the character sequencer.
// ----------------------------------------------------------------------------
module ahfb_cmd_fifo
  import ahfb_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  input  logic pop_i,
  output cmd_t data_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[hdl/ahfb_back.sv]
// ----------------------------------------------------------------------------
// ASCII hex frame builder back end
// Expands queued commands into frame characters, one per cycle while the
// output slot is free, with the running checksum and an output register.
// ----------------------------------------------------------------------------
module ahfb_back
  import ahfb_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cfg_t         cfg_i,
  input  cmd_t         cmd_i,
  input  logic         cmd_empty_i,
  input  logic         pop_i,
  output out_item_t    out_item_o,
  output logic         out_valid_o,
  output back_status_t status_o
);

  back_mode_e       mode_q, mode_d;
  logic [StepW-1:0] step_q, step_d;
  logic [15:0]      sum_q, sum_d;
  logic [7:0]       addr_q, addr_d;
  logic [7:0]       code_q, code_d;
  logic [7:0]       len_q, len_d;
  out_item_t        out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic        slot_free;
  logic [7:0]  ch;
  logic        fend;
  logic [15:0] chk;
  logic [3:0]  lchk;
  logic [3:0]  hdr_nib;
  logic [3:0]  trl_nib;

  assign slot_free = !out_valid_q || pop_i;
  assign chk       = 16'd0 - sum_q;
  assign lchk      = 4'd0 - (len_q[3:0] + len_q[7:4]);

  always_comb begin
    case (step_q)
      4'd1:    hdr_nib = cfg_i.protocol_version[7:4];
      4'd2:    hdr_nib = cfg_i.protocol_version[3:0];
      4'd3:    hdr_nib = addr_q[7:4];
      4'd4:    hdr_nib = addr_q[3:0];
      4'd5:    hdr_nib = cfg_i.device_type[7:4];
      4'd6:    hdr_nib = cfg_i.device_type[3:0];
      4'd7:    hdr_nib = code_q[7:4];
      4'd8:    hdr_nib = code_q[3:0];
      4'd9:    hdr_nib = lchk;
      4'd11:   hdr_nib = len_q[7:4];
      4'd12:   hdr_nib = len_q[3:0];
      default: hdr_nib = 4'h0;
    endcase
    case (step_q)
      4'd0:    trl_nib = chk[15:12];
      4'd1:    trl_nib = chk[11:8];
      4'd2:    trl_nib = chk[7:4];
      default: trl_nib = chk[3:0];
    endcase
  end

  always_comb begin
    mode_d           = mode_q;
    step_d           = step_q;
    sum_d            = sum_q;
    addr_d           = addr_q;
    code_d           = code_q;
    len_d            = len_q;
    ch               = 8'h00;
    fend             = 1'b0;
    status_o.emit    = 1'b0;
    status_o.cmd_pop = 1'b0;
    unique case (mode_q)
      BK_IDLE: begin
        if (slot_free && !cmd_empty_i) begin
          status_o.cmd_pop = 1'b1;
          status_o.emit    = 1'b1;
          if (cmd_i.kind == CMD_START) begin
            ch     = cfg_i.start_char;
            sum_d  = 16'd0;
            addr_d = cmd_i.addr;
            code_d = cmd_i.code;
            len_d  = cmd_i.data;
            mode_d = BK_HDR;
            step_d = HdrFirstStep;
          end else begin
            ch    = cmd_i.data;
            sum_d = sum_q + {8'h00, cmd_i.data};
            if (cmd_i.last) begin
              mode_d = BK_TRL;
              step_d = '0;
            end
          end
        end
      end
      BK_HDR: begin
        if (slot_free) begin
          status_o.emit = 1'b1;
          ch            = hex_char(hdr_nib);
          sum_d         = sum_q + {8'h00, ch};
          if (step_q == HdrLastStep) begin
            step_d = '0;
            mode_d = (len_q == 8'd0) ? BK_TRL : BK_IDLE;
          end else begin
            step_d = step_q + 1'b1;
          end
        end
      end
      BK_TRL: begin
        if (slot_free) begin
          status_o.emit = 1'b1;
          if (step_q == TrlLastStep) begin
            ch     = cfg_i.end_char;
            fend   = 1'b1;
            sum_d  = 16'd0;
            step_d = '0;
            mode_d = BK_IDLE;
          end else begin
            ch     = hex_char(trl_nib);
            step_d = step_q + 1'b1;
          end
        end
      end
      default: begin
        mode_d = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (status_o.emit) begin
      out_d.out_char  = ch;
      out_d.frame_end = fend;
      out_valid_d     = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= BK_IDLE;
      step_q      <= '0;
      sum_q       <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      step_q      <= step_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    code_q <= code_d;
    len_q  <= len_d;
    out_q  <= out_d;
  end

  assign out_item_o  = out_q;
  assign out_valid_o = out_valid_q;

endmodule
